@@ rtl/core/packed_stack_machine_core_defines.svh @@
// Assertion macros for the packed stack machine core.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PACKED_STACK_MACHINE_CORE_DEFINES_SVH
`define PACKED_STACK_MACHINE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("stack machine port check failed");

// The consequent must hold in the cycle after the antecedent.
`define PSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("stack machine port check failed");

`endif

@@ rtl/core/psm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

  // Memory and stack geometry.
  localparam int MEM_CELLS = 65536;
  localparam int ADDR_W    = $clog2(MEM_CELLS + 1);
  localparam int CELL_W    = 32;
  localparam int IN_W      = 32;
  localparam int DS_DEPTH  = 256;
  localparam int RS_DEPTH  = 256;
  localparam int DS_AW     = $clog2(DS_DEPTH);
  localparam int RS_AW     = $clog2(RS_DEPTH);
  localparam int SH_W      = $clog2(CELL_W);

  localparam logic [CELL_W-1:0] MEMC_CELL = CELL_W'(MEM_CELLS);

  // Input kinds as they arrive on the port.
  localparam logic [2:0] KIND_LOAD  = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_PUSH  = 3'd2;
  localparam logic [2:0] KIND_START = 3'd3;
  localparam logic [2:0] KIND_EXEC  = 3'd4;

  // Item classes handed from the front end to the executor.
  typedef logic [2:0] item_cls_t;
  localparam item_cls_t IC_LOAD  = 3'd0;
  localparam item_cls_t IC_READ  = 3'd1;
  localparam item_cls_t IC_PUSH  = 3'd2;
  localparam item_cls_t IC_START = 3'd3;
  localparam item_cls_t IC_EXEC  = 3'd4;
  localparam item_cls_t IC_NONE  = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // Opcodes.
  localparam logic [7:0] OP_NOP    = 8'd0;
  localparam logic [7:0] OP_LIT    = 8'd1;
  localparam logic [7:0] OP_DUP    = 8'd2;
  localparam logic [7:0] OP_DROP   = 8'd3;
  localparam logic [7:0] OP_SWAP   = 8'd4;
  localparam logic [7:0] OP_TOR    = 8'd5;
  localparam logic [7:0] OP_FROMR  = 8'd6;
  localparam logic [7:0] OP_JUMP   = 8'd7;
  localparam logic [7:0] OP_CALL   = 8'd8;
  localparam logic [7:0] OP_CCALL  = 8'd9;
  localparam logic [7:0] OP_RET    = 8'd10;
  localparam logic [7:0] OP_EQ     = 8'd11;
  localparam logic [7:0] OP_NEQ    = 8'd12;
  localparam logic [7:0] OP_LT     = 8'd13;
  localparam logic [7:0] OP_GT     = 8'd14;
  localparam logic [7:0] OP_FETCH  = 8'd15;
  localparam logic [7:0] OP_STORE  = 8'd16;
  localparam logic [7:0] OP_ADD    = 8'd17;
  localparam logic [7:0] OP_SUB    = 8'd18;
  localparam logic [7:0] OP_MUL    = 8'd19;
  localparam logic [7:0] OP_DIVMOD = 8'd20;
  localparam logic [7:0] OP_AND    = 8'd21;
  localparam logic [7:0] OP_OR     = 8'd22;
  localparam logic [7:0] OP_XOR    = 8'd23;
  localparam logic [7:0] OP_SHIFT  = 8'd24;
  localparam logic [7:0] OP_ZRET   = 8'd25;
  localparam logic [7:0] OP_HALT   = 8'd26;
  localparam logic [7:0] OP_DEVN   = 8'd27;
  localparam logic [7:0] OP_QUERY  = 8'd28;
  localparam logic [7:0] OP_IO     = 8'd29;
  localparam logic [7:0] OP_MAX    = OP_IO;

  // One queued item.
  typedef struct packed {
    item_cls_t           cls;
    logic                addr_ok;
    logic [ADDR_W-1:0]   address;
    logic [CELL_W-1:0]   value;
  } item_t;

  // Control from the executor back to the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } qctl_t;

endpackage

`default_nettype wire

@@ rtl/core/psm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module psm_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2:0]             kind,
  input  logic [psm_pkg::ADDR_W-1:0] address,
  input  logic [psm_pkg::IN_W-1:0]   value,
  output logic                   busy,
  output psm_pkg::item_t         head,
  output logic                   head_valid,
  input  psm_pkg::qctl_t         qctl
);
  import psm_pkg::*;

  item_t      q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       accept;
  item_t      in_item;

  // Classify the incoming word.
  always_comb begin
    in_item.address = address;
    in_item.value   = CELL_W'(signed'(value));
    in_item.addr_ok = (address <= ADDR_W'(MEM_CELLS));
    case (kind)
      KIND_LOAD:  in_item.cls = IC_LOAD;
      KIND_READ:  in_item.cls = IC_READ;
      KIND_PUSH:  in_item.cls = IC_PUSH;
      KIND_START: in_item.cls = IC_START;
      KIND_EXEC:  in_item.cls = IC_EXEC;
      default:    in_item.cls = IC_NONE;
    endcase
  end

  assign busy       = (cnt == 2'd2) || qctl.clearing;
  assign accept     = start && !busy;
  assign head       = q[rd_ptr];
  assign head_valid = (cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= !wr_ptr;
      end
      if (qctl.pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (accept && !qctl.pop) begin
        cnt <= cnt + 2'd1;
      end else if (!accept && qctl.pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/psm_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module psm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [psm_pkg::CELL_W-1:0] dividend,
  input  logic [psm_pkg::CELL_W-1:0] divisor,
  output logic                       done,
  output logic [psm_pkg::CELL_W-1:0] quo,
  output logic [psm_pkg::CELL_W-1:0] rem
);
  import psm_pkg::*;

  logic [CELL_W-1:0] dsr;
  logic [SH_W-1:0]   cnt;
  logic              run;
  logic [CELL_W:0]   sh;
  logic [CELL_W:0]   trial;

  // One restoring step per cycle, most significant quotient bit first.
  assign sh    = {rem, quo[CELL_W-1]};
  assign trial = sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (run) begin
      if (!trial[CELL_W]) begin
        rem <= trial[CELL_W-1:0];
        quo <= {quo[CELL_W-2:0], 1'b1};
      end else begin
        rem <= sh[CELL_W-1:0];
        quo <= {quo[CELL_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == '0);
      if (start) begin
        run <= 1'b1;
        cnt <= SH_W'(CELL_W - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/psm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module psm_back (
  input  logic                       clk,
  input  logic                       rst,
  input  psm_pkg::item_t             head,
  input  logic                       head_valid,
  output psm_pkg::qctl_t             qctl,
  output logic                       done,
  output logic                       result_kind,
  output logic [7:0]                 out_char,
  output logic [1:0]                 status,
  output logic [31:0]                read_data,
  output logic [psm_pkg::ADDR_W-1:0] program_counter,
  output logic                       last
);
  import psm_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MWAIT = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_EX    = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_WB1   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_STAT  = 4'd9;

  localparam logic [CELL_W-1:0] NEG1   = '1;
  localparam logic [CELL_W-1:0] NEG2   = NEG1 - CELL_W'(1);
  localparam logic [CELL_W-1:0] NEG3   = NEG1 - CELL_W'(2);
  localparam logic [CELL_W-1:0] NEG4   = NEG1 - CELL_W'(3);
  localparam logic [CELL_W-1:0] NEG5   = NEG1 - CELL_W'(4);
  localparam logic [CELL_W-1:0] MINP1  = {1'b1, {(CELL_W-2){1'b0}}, 1'b1};
  localparam logic [CELL_W-1:0] MAXM1  = {1'b0, {(CELL_W-2){1'b1}}, 1'b0};

  function automatic logic [DS_AW-1:0] ds_inc(input logic [DS_AW-1:0] p);
    ds_inc = (p == DS_AW'(DS_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [DS_AW-1:0] ds_dec(input logic [DS_AW-1:0] p);
    ds_dec = (p == '0) ? DS_AW'(DS_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [RS_AW-1:0] rs_inc(input logic [RS_AW-1:0] p);
    rs_inc = (p == RS_AW'(RS_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [RS_AW-1:0] rs_dec(input logic [RS_AW-1:0] p);
    rs_dec = (p == '0) ? RS_AW'(RS_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic in_mem(input logic [CELL_W-1:0] x);
    in_mem = !x[CELL_W-1] && (x <= MEMC_CELL);
  endfunction

  // Control and machine state.
  logic [3:0]        state;
  logic [ADDR_W-1:0] clr_cnt;
  logic [DS_AW-1:0]  dp;
  logic [RS_AW-1:0]  rp;
  logic [ADDR_W-1:0] pc;
  logic [CELL_W-1:0] wip;
  logic [31:0]       word;
  logic [1:0]        op_idx;
  logic              aux;
  logic              is_read;
  logic [1:0]        stat;
  logic [31:0]       rd;
  logic [7:0]        ebuf [4];
  logic [2:0]        ecnt;
  logic [1:0]        eidx;
  logic              w1e;
  logic [DS_AW-1:0]  w1a;
  logic [CELL_W-1:0] w1d;

  // Memories and their ports.
  logic [CELL_W-1:0] cmem [0:MEM_CELLS];
  logic [CELL_W-1:0] dstk [0:DS_DEPTH-1];
  logic [CELL_W-1:0] rstk [0:RS_DEPTH-1];
  logic              cm_we, cm_re;
  logic [ADDR_W-1:0] cm_wa, cm_ra;
  logic [CELL_W-1:0] cm_wd, cm_q;
  logic              ds_we;
  logic [DS_AW-1:0]  ds_wa;
  logic [CELL_W-1:0] ds_wd, ds_q0, ds_q1;
  logic              rs_we;
  logic [RS_AW-1:0]  rs_wa;
  logic [CELL_W-1:0] rs_wd, rs_q;

  // Operand views and neighbors.
  logic [7:0]        op;
  logic [CELL_W-1:0] tos, nos, rtos, mrd;
  logic [DS_AW-1:0]  dp1, dm1, dm2;
  logic [RS_AW-1:0]  rp1, rm1;
  logic [CELL_W-1:0] wip_p1, wip_d1, wip_d2, tos_m1;
  logic              word_bad;
  logic              fin_end;
  logic              fetch_wait, div_start, commit;

  // Execute results.
  logic              e_w0e, e_w1e, e_rwe, e_mwe, e_emit;
  logic [DS_AW-1:0]  e_w0a, e_w1a, e_dp;
  logic [CELL_W-1:0] e_w0d, e_w1d, e_rwd, e_mwd, e_wip;
  logic [RS_AW-1:0]  e_rwa, e_rp;
  logic [ADDR_W-1:0] e_mwa;

  // Arithmetic.
  logic [CELL_W-1:0] bin_v, mul_lo, sh_res, sh_kn, fetch_v;
  logic [CELL_W-1:0] ua, ub, dq, dr, q_s, r_s;
  logic              div_done;

  assign op     = word[8*op_idx +: 8];
  assign tos    = ds_q0;
  assign nos    = ds_q1;
  assign rtos   = rs_q;
  assign mrd    = cm_q;
  assign dp1    = ds_inc(dp);
  assign dm1    = ds_dec(dp);
  assign dm2    = ds_dec(dm1);
  assign rp1    = rs_inc(rp);
  assign rm1    = rs_dec(rp);
  assign wip_p1 = wip + CELL_W'(1);
  assign wip_d1 = (dp == '0) ? MEMC_CELL : wip;
  assign wip_d2 = (dp == '0 || dm1 == '0) ? MEMC_CELL : wip;
  assign tos_m1 = tos - CELL_W'(1);

  assign word_bad = (cm_q[7:0] > OP_MAX) || (cm_q[15:8] > OP_MAX) ||
                    (cm_q[23:16] > OP_MAX) || (cm_q[31:24] > OP_MAX);
  assign fin_end  = (rp == '0) || wip_p1[CELL_W-1] || (wip_p1 >= MEMC_CELL);

  assign fetch_wait = (state == S_EX) && (op == OP_FETCH) && !aux;
  assign div_start  = (state == S_EX) && (op == OP_DIVMOD) && (tos != '0) && !aux;
  assign commit     = (state == S_EX) && !fetch_wait && !div_start;

  // Multiply, shift and the signed wrapper around the unsigned divider.
  assign mul_lo = nos * tos;
  assign sh_kn  = '0 - tos;
  always_comb begin
    if (tos[CELL_W-1]) begin
      sh_res = (|sh_kn[CELL_W-1:SH_W]) ? '0 : (nos << sh_kn[SH_W-1:0]);
    end else if (|tos[CELL_W-1:SH_W]) begin
      sh_res = {CELL_W{nos[CELL_W-1]}};
    end else begin
      sh_res = unsigned'($signed(nos) >>> tos[SH_W-1:0]);
    end
  end

  assign ua  = tos[CELL_W-1] ? ('0 - tos) : tos;
  assign ub  = nos[CELL_W-1] ? ('0 - nos) : nos;
  assign q_s = (tos == '0) ? '0 : ((tos[CELL_W-1] ^ nos[CELL_W-1]) ? ('0 - dq) : dq);
  assign r_s = (tos == '0) ? '0 : (nos[CELL_W-1] ? ('0 - dr) : dr);

  psm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ub),
    .divisor  (ua),
    .done     (div_done),
    .quo      (dq),
    .rem      (dr)
  );

  always_comb begin
    case (op)
      OP_EQ:   bin_v = (nos == tos) ? NEG1 : '0;
      OP_NEQ:  bin_v = (nos != tos) ? NEG1 : '0;
      OP_LT:   bin_v = ($signed(nos) < $signed(tos)) ? NEG1 : '0;
      OP_GT:   bin_v = ($signed(tos) < $signed(nos)) ? NEG1 : '0;
      OP_ADD:  bin_v = nos + tos;
      OP_SUB:  bin_v = nos - tos;
      OP_MUL:  bin_v = mul_lo;
      OP_AND:  bin_v = nos & tos;
      OP_OR:   bin_v = nos | tos;
      OP_XOR:  bin_v = nos ^ tos;
      OP_SHIFT: bin_v = sh_res;
      default: bin_v = '0;
    endcase
  end

  always_comb begin
    if (tos == NEG1) begin
      fetch_v = CELL_W'(dp) - CELL_W'(1);
    end else if (tos == NEG2) begin
      fetch_v = CELL_W'(rp);
    end else if (tos == NEG3) begin
      fetch_v = MEMC_CELL;
    end else if (tos == NEG4) begin
      fetch_v = MINP1;
    end else if (tos == NEG5) begin
      fetch_v = MAXM1;
    end else begin
      fetch_v = in_mem(tos) ? mrd : '0;
    end
  end

  // Effect of one opcode: up to two data stack writes, one return stack
  // write and one memory write.
  always_comb begin
    e_w0e = 1'b0; e_w0a = dp;  e_w0d = '0;
    e_w1e = 1'b0; e_w1a = dm1; e_w1d = '0;
    e_rwe = 1'b0; e_rwa = rp1; e_rwd = wip;
    e_mwe = 1'b0; e_mwa = tos[ADDR_W-1:0]; e_mwd = nos;
    e_dp  = dp;   e_rp  = rp;  e_wip = wip;  e_emit = 1'b0;
    case (op)
      OP_LIT: begin
        e_dp = dp1; e_wip = wip_p1;
        e_w0e = 1'b1; e_w0a = dp1; e_w0d = in_mem(wip_p1) ? mrd : '0;
      end
      OP_DUP: begin
        e_dp = dp1; e_w0e = 1'b1; e_w0a = dp1; e_w0d = tos;
      end
      OP_DROP: begin
        e_w0e = 1'b1; e_wip = wip_d1; e_dp = dm1;
      end
      OP_SWAP: begin
        e_w0e = 1'b1; e_w0d = nos;
        e_w1e = 1'b1; e_w1d = tos;
      end
      OP_TOR: begin
        e_rp = rp1; e_rwe = 1'b1; e_rwd = tos;
        e_w0e = 1'b1; e_wip = wip_d1; e_dp = dm1;
      end
      OP_FROMR: begin
        e_dp = dp1; e_w0e = 1'b1; e_w0a = dp1; e_w0d = rtos; e_rp = rm1;
      end
      OP_JUMP: begin
        e_wip = (dp == '0) ? MEMC_CELL : tos_m1;
        e_w0e = 1'b1; e_dp = dm1;
      end
      OP_CALL: begin
        e_rp = rp1; e_rwe = 1'b1; e_rwd = wip;
        e_wip = (dp == '0) ? MEMC_CELL : tos_m1;
        e_w0e = 1'b1; e_dp = dm1;
      end
      OP_CCALL: begin
        e_w0e = 1'b1; e_w1e = 1'b1; e_dp = dm2;
        if (nos != '0) begin
          e_rp = rp1; e_rwe = 1'b1; e_rwd = wip_d2; e_wip = tos_m1;
        end else begin
          e_wip = wip_d2;
        end
      end
      OP_RET: begin
        e_wip = rtos; e_rp = rm1;
      end
      OP_EQ, OP_NEQ, OP_LT, OP_GT, OP_ADD, OP_SUB, OP_MUL,
      OP_AND, OP_OR, OP_XOR, OP_SHIFT: begin
        // Result replaces the second item, then the top is dropped.
        e_w0e = 1'b1; e_w0a = dm1; e_w0d = bin_v;
        e_w1e = 1'b1; e_w1a = dp;  e_w1d = '0;
        e_wip = wip_d1; e_dp = dm1;
      end
      OP_FETCH: begin
        e_w0e = 1'b1; e_w0d = fetch_v;
      end
      OP_STORE: begin
        if (in_mem(tos)) begin
          e_mwe = 1'b1;
          e_w0e = 1'b1; e_w1e = 1'b1; e_wip = wip_d2; e_dp = dm2;
        end else begin
          e_wip = MEMC_CELL;
        end
      end
      OP_DIVMOD: begin
        e_w0e = 1'b1; e_w0d = q_s;
        e_w1e = 1'b1; e_w1d = r_s;
      end
      OP_ZRET: begin
        if (tos == '0) begin
          e_w0e = 1'b1; e_dp = dm1; e_wip = rtos; e_rp = rm1;
        end
      end
      OP_HALT: begin
        e_wip = MEMC_CELL;
      end
      OP_DEVN: begin
        e_dp = dp1; e_w0e = 1'b1; e_w0a = dp1; e_w0d = CELL_W'(1);
      end
      OP_QUERY: begin
        e_w0e = 1'b1; e_wip = wip_d1; e_dp = dm1;
        if (tos == '0) begin
          e_w1e = 1'b1; e_w1a = dp1; e_dp = dp1;
        end
      end
      OP_IO: begin
        e_w0e = 1'b1; e_wip = wip_d1; e_dp = dm1;
        if (tos == '0) begin
          e_w1e = 1'b1; e_wip = wip_d2; e_dp = dm2; e_emit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Cell memory port selection.
  always_comb begin
    cm_we = 1'b0; cm_wa = clr_cnt; cm_wd = '0;
    cm_re = 1'b0; cm_ra = pc;
    case (state)
      S_CLEAR: begin
        cm_we = 1'b1;
      end
      S_IDLE: begin
        if (head_valid && head.cls == IC_LOAD && head.addr_ok) begin
          cm_we = 1'b1; cm_wa = head.address; cm_wd = head.value;
        end
        if (head_valid && head.cls == IC_READ && head.addr_ok) begin
          cm_re = 1'b1; cm_ra = head.address;
        end
        if (head_valid && head.cls == IC_EXEC && pc < ADDR_W'(MEM_CELLS)) begin
          cm_re = 1'b1; cm_ra = pc;
        end
      end
      S_RD: begin
        cm_re = in_mem(wip_p1); cm_ra = wip_p1[ADDR_W-1:0];
      end
      S_EX: begin
        if (fetch_wait) begin
          cm_re = in_mem(tos); cm_ra = tos[ADDR_W-1:0];
        end
        if (commit && e_mwe) begin
          cm_we = 1'b1; cm_wa = e_mwa; cm_wd = e_mwd;
        end
      end
      default: begin
      end
    endcase
  end

  // Data and return stack write ports.
  always_comb begin
    ds_we = 1'b0; ds_wa = dp; ds_wd = '0;
    rs_we = 1'b0; rs_wa = rp; rs_wd = '0;
    case (state)
      S_CLEAR: begin
        ds_we = (clr_cnt < ADDR_W'(DS_DEPTH)); ds_wa = clr_cnt[DS_AW-1:0];
        rs_we = (clr_cnt < ADDR_W'(RS_DEPTH)); rs_wa = clr_cnt[RS_AW-1:0];
      end
      S_IDLE: begin
        if (head_valid && head.cls == IC_PUSH) begin
          ds_we = 1'b1; ds_wa = dp1; ds_wd = head.value;
        end
      end
      S_EX: begin
        if (commit) begin
          ds_we = e_w0e; ds_wa = e_w0a; ds_wd = e_w0d;
          rs_we = e_rwe; rs_wa = e_rwa; rs_wd = e_rwd;
        end
      end
      S_WB1: begin
        ds_we = w1e; ds_wa = w1a; ds_wd = w1d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[cm_wa] <= cm_wd;
    end
    if (cm_re) begin
      cm_q <= cmem[cm_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ds_we) begin
      dstk[ds_wa] <= ds_wd;
    end
    ds_q0 <= dstk[dp];
    ds_q1 <= dstk[dm1];
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rstk[rs_wa] <= rs_wd;
    end
    rs_q <= rstk[rp];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && head_valid) begin
      rd   <= '0;
      stat <= (head.cls == IC_EXEC && pc >= ADDR_W'(MEM_CELLS)) ? ST_DONE : ST_RUN;
    end
    if (state == S_MWAIT) begin
      if (is_read) begin
        rd <= cm_q[31:0];
      end else begin
        word <= cm_q[31:0];
        wip  <= CELL_W'(pc);
        if (word_bad) begin
          stat <= ST_BAD;
        end
      end
    end
    if (commit) begin
      wip <= e_wip;
      w1a <= e_w1a;
      w1d <= e_w1d;
      if (e_emit) begin
        ebuf[ecnt[1:0]] <= nos[7:0];
      end
    end
    if (state == S_FIN) begin
      stat <= fin_end ? ST_DONE : ST_RUN;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      dp      <= '0;
      rp      <= '0;
      pc      <= '0;
      op_idx  <= 2'd0;
      aux     <= 1'b0;
      is_read <= 1'b0;
      ecnt    <= 3'd0;
      eidx    <= 2'd0;
      w1e     <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == ADDR_W'(MEM_CELLS)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_valid) begin
            ecnt <= 3'd0;
            case (head.cls)
              IC_READ: begin
                if (head.addr_ok) begin
                  is_read <= 1'b1;
                  state   <= S_MWAIT;
                end else begin
                  state <= S_STAT;
                end
              end
              IC_PUSH: begin
                dp    <= dp1;
                state <= S_STAT;
              end
              IC_START: begin
                rp    <= RS_AW'(1);
                pc    <= head.address;
                state <= S_STAT;
              end
              IC_EXEC: begin
                if (pc < ADDR_W'(MEM_CELLS)) begin
                  is_read <= 1'b0;
                  state   <= S_MWAIT;
                end else begin
                  state <= S_STAT;
                end
              end
              default: begin
                state <= S_STAT;
              end
            endcase
          end
        end
        S_MWAIT: begin
          if (is_read || word_bad) begin
            state <= S_STAT;
          end else begin
            op_idx <= 2'd0;
            state  <= S_RD;
          end
        end
        S_RD: begin
          state <= S_EX;
        end
        S_EX: begin
          if (fetch_wait) begin
            aux <= 1'b1;
          end else if (div_start) begin
            state <= S_DIV;
          end else begin
            aux <= 1'b0;
            dp  <= e_dp;
            rp  <= e_rp;
            w1e <= e_w1e;
            if (e_emit) begin
              ecnt <= ecnt + 3'd1;
            end
            if (e_w1e) begin
              state <= S_WB1;
            end else begin
              op_idx <= op_idx + 2'd1;
              state  <= (op_idx == 2'd3) ? S_FIN : S_RD;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            aux   <= 1'b1;
            state <= S_EX;
          end
        end
        S_WB1: begin
          op_idx <= op_idx + 2'd1;
          state  <= (op_idx == 2'd3) ? S_FIN : S_RD;
        end
        S_FIN: begin
          pc   <= fin_end ? ADDR_W'(MEM_CELLS) : wip_p1[ADDR_W-1:0];
          eidx <= 2'd0;
          state <= (ecnt != 3'd0) ? S_EMIT : S_STAT;
        end
        S_EMIT: begin
          eidx <= eidx + 2'd1;
          if (3'(eidx) == ecnt - 3'd1) begin
            state <= S_STAT;
          end
        end
        S_STAT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign qctl.pop      = (state == S_IDLE) && head_valid;
  assign qctl.clearing = (state == S_CLEAR);

  assign done            = (state == S_EMIT) || (state == S_STAT);
  assign result_kind     = (state == S_STAT);
  assign out_char        = (state == S_EMIT) ? ebuf[eidx] : 8'd0;
  assign status          = (state == S_STAT) ? stat : ST_RUN;
  assign read_data       = (state == S_STAT) ? rd : 32'd0;
  assign program_counter = pc;
  assign last            = (state == S_STAT);

endmodule

`default_nettype wire

@@ rtl/core/packed_stack_machine_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Packed stack machine core. A word is offered with start and taken on a
// clock edge where busy is low; results come back on the result ports, each
// marked by done for exactly one cycle, and the receiver cannot stall them,
// so it must take every result the cycle it appears. Every accepted word
// gives zero or more character results (result_kind 0) followed by one status
// result (result_kind 1, last 1), in the order the words were taken.
//
// After reset the core clears its 65537-cell memory and both 256-entry stacks
// one entry per cycle, with busy high until the clearing pass ends and the
// first word can be taken. Words then pass through a two-entry queue to the
// executor. Load, read, push, start and unused kinds go straight to their
// status result, a valid read through a memory wait first. An execute word
// fetches and checks the cell, then each of its four opcodes takes a stack
// read and an execute step, plus a write-back step when it writes a second
// stack entry, a second execute pass for a fetch, and a divider pass for a
// divmod, which runs through a one-bit-per-cycle divider. A finishing step,
// an emit step for each output character and the status step follow. The
// single data stack write port and registered memory read cause the extra steps.

module packed_stack_machine_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 kind,
  input  logic [psm_pkg::ADDR_W-1:0] address,
  input  logic [psm_pkg::IN_W-1:0]   value,
  output logic                       done,
  output logic                       result_kind,
  output logic [7:0]                 out_char,
  output logic [1:0]                 status,
  output logic [31:0]                read_data,
  output logic [psm_pkg::ADDR_W-1:0] program_counter,
  output logic                       last
);
  import psm_pkg::*;

  // Queue head and the executor's pop and clear-in-progress signals.
  item_t head;
  logic  head_valid;
  qctl_t qctl;

  // The front end classifies words and holds them until the executor is free.
  psm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .kind       (kind),
    .address    (address),
    .value      (value),
    .busy       (busy),
    .head       (head),
    .head_valid (head_valid),
    .qctl       (qctl)
  );

  // The executor owns the cell memory, both stacks and the registers.
  psm_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .head_valid      (head_valid),
    .qctl            (qctl),
    .done            (done),
    .result_kind     (result_kind),
    .out_char        (out_char),
    .status          (status),
    .read_data       (read_data),
    .program_counter (program_counter),
    .last            (last)
  );

endmodule

`default_nettype wire

@@ rtl/core/psm_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "packed_stack_machine_core_defines.svh"

module psm_chk (
  input logic       clk,
  input logic       rst,
  input logic       busy,
  input logic       done,
  input logic       result_kind,
  input logic [7:0] out_char,
  input logic [1:0] status,
  input logic       last
);
  import psm_pkg::*;

  // Reset starts the clearing pass: nothing comes out and nothing is taken.
  `PSM_ASSERT_NEXT(a_rst_quiet, rst, !done && busy)

  // Character results never end a word and carry no status.
  `PSM_ASSERT_NOW(a_char_not_last, !rst && done && !result_kind, !last && status == ST_RUN)

  // The status result is the last one and carries no character.
  `PSM_ASSERT_NOW(a_status_last, !rst && done && result_kind, last && out_char == 8'd0)

  // Results of one word come back to back until the last one.
  `PSM_ASSERT_NEXT(a_results_burst, !rst && done && !last, done)

endmodule

bind packed_stack_machine_core psm_chk u_psm_chk (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .done        (done),
  .result_kind (result_kind),
  .out_char    (out_char),
  .status      (status),
  .last        (last)
);

`default_nettype wire

@@ bench/tb_packed_stack_machine_core.sv @@
`timescale 1ns / 1ps

module tb_packed_stack_machine_core;
  import psm_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int         MAX_EMITS     = 4;
  localparam int         WORD_TARGET   = 210;

  typedef struct {
    logic [2:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [31:0]       value;
  } word_t;

  typedef struct {
    logic              result_kind;
    logic [7:0]        out_char;
    logic [1:0]        status;
    logic [31:0]       read_data;
    logic [ADDR_W-1:0] program_counter;
    logic              last;
  } result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [2:0]        kind = '0;
  logic [ADDR_W-1:0] address = '0;
  logic [31:0]       value = '0;
  logic              done;
  logic              result_kind;
  logic [7:0]        out_char;
  logic [1:0]        status;
  logic [31:0]       read_data;
  logic [ADDR_W-1:0] program_counter;
  logic              last;

  packed_stack_machine_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .address(address),
    .value(value), .done(done), .result_kind(result_kind), .out_char(out_char),
    .status(status), .read_data(read_data), .program_counter(program_counter),
    .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  word_t   pending_words[$];
  result_t expected_results[$];
  int      mismatches = 0;
  int      words_taken = 0;
  int      words_total = 0;

  // Shadow copy of the machine state.
  logic [31:0]       mem_model [0:MEM_CELLS];
  logic [31:0]       dstack [0:DS_DEPTH-1];
  logic [31:0]       rstack [0:RS_DEPTH-1];
  int                dptr, rptr;
  logic [ADDR_W-1:0] pc_model;
  logic [31:0]       wip;
  logic [7:0]        emitted[$];

  function automatic int wrap_inc(int p, int depth);
    return (p + 1 >= depth) ? 0 : p + 1;
  endfunction

  function automatic int wrap_dec(int p, int depth);
    return (p == 0) ? depth - 1 : p - 1;
  endfunction

  function automatic logic [31:0] mem_fetch(logic [31:0] a);
    if (a[31] || a > MEM_CELLS) return '0;
    return mem_model[a];
  endfunction

  function automatic void dpush(logic [31:0] v);
    dptr = wrap_inc(dptr, DS_DEPTH);
    dstack[dptr] = v;
  endfunction

  // Dropping below the bottom of the data stack halts the machine.
  function automatic void ddrop();
    dstack[dptr] = '0;
    if (dptr == 0) wip = MEM_CELLS;
    dptr = wrap_dec(dptr, DS_DEPTH);
  endfunction

  function automatic void rpush(logic [31:0] v);
    rptr = wrap_inc(rptr, RS_DEPTH);
    rstack[rptr] = v;
  endfunction

  function automatic void fold_binary(logic [31:0] v);
    dstack[wrap_dec(dptr, DS_DEPTH)] = v;
    ddrop();
  endfunction

  function automatic void run_opcode(logic [7:0] op);
    logic [31:0] t, n, a, b, q, r, ua, ub, res;
    int          k;
    t = dstack[dptr];
    n = dstack[wrap_dec(dptr, DS_DEPTH)];
    case (op)
      OP_LIT: begin
        dptr = wrap_inc(dptr, DS_DEPTH);
        wip = wip + 1;
        dstack[dptr] = mem_fetch(wip);
      end
      OP_DUP:   dpush(t);
      OP_DROP:  ddrop();
      OP_SWAP: begin
        dstack[dptr] = n;
        dstack[wrap_dec(dptr, DS_DEPTH)] = t;
      end
      OP_TOR: begin
        rpush(t);
        ddrop();
      end
      OP_FROMR: begin
        dpush(rstack[rptr]);
        rptr = wrap_dec(rptr, RS_DEPTH);
      end
      OP_JUMP: begin
        wip = t - 1;
        ddrop();
      end
      OP_CALL: begin
        rpush(wip);
        wip = t - 1;
        ddrop();
      end
      OP_CCALL: begin
        ddrop();
        b = dstack[dptr];
        ddrop();
        if (b != 0) begin
          rpush(wip);
          wip = t - 1;
        end
      end
      OP_RET: begin
        wip = rstack[rptr];
        rptr = wrap_dec(rptr, RS_DEPTH);
      end
      OP_EQ:  fold_binary((n == t) ? '1 : '0);
      OP_NEQ: fold_binary((n != t) ? '1 : '0);
      OP_LT:  fold_binary(($signed(n) < $signed(t)) ? '1 : '0);
      OP_GT:  fold_binary(($signed(n) > $signed(t)) ? '1 : '0);
      OP_FETCH: begin
        // Small negative addresses query machine geometry instead of memory.
        if (t == 32'hFFFF_FFFF)      dstack[dptr] = dptr - 1;
        else if (t == 32'hFFFF_FFFE) dstack[dptr] = rptr;
        else if (t == 32'hFFFF_FFFD) dstack[dptr] = MEM_CELLS;
        else if (t == 32'hFFFF_FFFC) dstack[dptr] = 32'h8000_0001;
        else if (t == 32'hFFFF_FFFB) dstack[dptr] = 32'h7FFF_FFFE;
        else                         dstack[dptr] = mem_fetch(t);
      end
      OP_STORE: begin
        if (!t[31] && t <= MEM_CELLS) begin
          mem_model[t] = n;
          ddrop();
          ddrop();
        end else begin
          wip = MEM_CELLS;
        end
      end
      OP_ADD: fold_binary(n + t);
      OP_SUB: fold_binary(n - t);
      OP_MUL: fold_binary(n * t);
      OP_DIVMOD: begin
        q = '0;
        r = '0;
        if (t != 0) begin
          ua = t[31] ? -t : t;
          ub = n[31] ? -n : n;
          q = ub / ua;
          r = ub % ua;
          if (t[31] != n[31]) q = -q;
          if (n[31]) r = -r;
        end
        dstack[dptr] = q;
        dstack[wrap_dec(dptr, DS_DEPTH)] = r;
      end
      OP_AND: fold_binary(n & t);
      OP_OR:  fold_binary(n | t);
      OP_XOR: fold_binary(n ^ t);
      OP_SHIFT: begin
        // Negative counts shift left; positive counts shift right arithmetically.
        if (t[31]) begin
          a = -t;
          res = (a >= CELL_W) ? '0 : n << a[4:0];
        end else if (t >= CELL_W) begin
          res = n[31] ? '1 : '0;
        end else begin
          k = t;
          res = $signed(n) >>> k;
        end
        fold_binary(res);
      end
      OP_ZRET: begin
        if (t == 0) begin
          ddrop();
          wip = rstack[rptr];
          rptr = wrap_dec(rptr, RS_DEPTH);
        end
      end
      OP_HALT: wip = MEM_CELLS;
      OP_DEVN: dpush(32'd1);
      OP_QUERY: begin
        ddrop();
        if (t == 0) begin
          dpush('0);
          dpush('0);
        end
      end
      OP_IO: begin
        ddrop();
        if (t == 0) begin
          b = dstack[dptr];
          ddrop();
          if (emitted.size() < MAX_EMITS) emitted.push_back(b[7:0]);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [1:0] execute_at_pc();
    logic [31:0] w;
    if (pc_model >= MEM_CELLS) return ST_DONE;
    w = mem_model[pc_model];
    for (int i = 0; i < 4; i++)
      if (w[8*i +: 8] > OP_MAX) return ST_BAD;
    wip = 32'(pc_model);
    for (int i = 0; i < 4; i++) run_opcode(w[8*i +: 8]);
    wip = wip + 1;
    if (rptr == 0 || wip[31] || wip >= MEM_CELLS) begin
      pc_model = ADDR_W'(MEM_CELLS);
      return ST_DONE;
    end
    pc_model = wip[ADDR_W-1:0];
    return ST_RUN;
  endfunction

  // Applies one accepted word to the shadow state and queues its results.
  function automatic void machine_step(word_t w);
    result_t     res;
    logic [31:0] rd;
    logic [1:0]  st;
    rd = '0;
    st = ST_RUN;
    emitted.delete();
    case (w.kind)
      KIND_LOAD:  if (w.address <= MEM_CELLS) mem_model[w.address] = w.value;
      KIND_READ:  if (w.address <= MEM_CELLS) rd = mem_model[w.address];
      KIND_PUSH:  dpush(w.value);
      KIND_START: begin
        rptr = 1;
        pc_model = w.address;
      end
      KIND_EXEC:  st = execute_at_pc();
      default: ;
    endcase
    foreach (emitted[i]) begin
      res = '{1'b0, emitted[i], ST_RUN, 32'd0, pc_model, 1'b0};
      expected_results.push_back(res);
    end
    res = '{1'b1, 8'd0, st, rd, pc_model, 1'b1};
    expected_results.push_back(res);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Stimulus helpers.
  task automatic add_word(logic [2:0] k, logic [ADDR_W-1:0] a, logic [31:0] v);
    word_t w;
    w = '{k, a, v};
    pending_words.push_back(w);
  endtask

  function automatic logic [31:0] pack_ops(logic [7:0] o0, logic [7:0] o1,
                                           logic [7:0] o2, logic [7:0] o3);
    return {o3, o2, o1, o0};
  endfunction

  // Loads a cell at addr, starts there with the given operands, and runs it.
  task automatic run_one(logic [ADDR_W-1:0] addr, logic [31:0] ops,
                         logic [31:0] below, logic [31:0] top);
    add_word(KIND_LOAD, addr, ops);
    add_word(KIND_PUSH, '0, below);
    add_word(KIND_PUSH, '0, top);
    add_word(KIND_START, addr, '0);
    add_word(KIND_EXEC, '0, '0);
  endtask

  function automatic logic [7:0] pick_opcode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return OP_IO;
    if (r < 20) return OP_LIT;
    if (r < 24) return OP_NOP;
    return 8'($urandom_range(0, OP_MAX));
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0, 1: return 32'($urandom_range(0, 3));
      2:    return 32'($urandom_range(0, 40)) - 32'd8;
      3:    return 32'h41 + 32'($urandom_range(0, 25));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_program();
    logic [ADDR_W-1:0] base;
    logic [31:0]       w;
    int                cells;
    base  = ($urandom_range(0, 9) == 0) ? ADDR_W'($urandom_range(MEM_CELLS - 6, MEM_CELLS - 1))
                                        : ADDR_W'($urandom_range(0, 300));
    cells = $urandom_range(2, 5);
    for (int i = 0; i < cells; i++) begin
      w = pack_ops(pick_opcode(), pick_opcode(), pick_opcode(), pick_opcode());
      if ($urandom_range(0, 11) == 0) w[8*$urandom_range(0, 3) +: 8] = 8'($urandom_range(30, 255));
      if ($urandom_range(0, 7) == 0) w = pick_operand();
      add_word(KIND_LOAD, ADDR_W'(base + i), w);
    end
    for (int i = $urandom_range(1, 4); i > 0; i--) add_word(KIND_PUSH, '0, pick_operand());
    if ($urandom_range(0, 15) == 0) add_word(KIND_START, ADDR_W'($urandom), '0);
    else add_word(KIND_START, base, '0);
    for (int i = $urandom_range(2, 6); i > 0; i--) begin
      if ($urandom_range(0, 4) == 0) add_word(KIND_PUSH, '0, pick_operand());
      add_word(KIND_EXEC, '0, '0);
    end
    if ($urandom_range(0, 2) == 0)
      add_word(KIND_READ, ADDR_W'(base + $urandom_range(0, cells)), '0);
  endtask

  task automatic random_noise();
    add_word(3'($urandom_range(0, 7)), ADDR_W'($urandom), $urandom);
  endtask

  // Driver: takes the head of the pending words when the core accepts it.
  always @(posedge clk) begin
    int    gap_pct;
    logic  next_start;
    word_t w;
    if (!rst) begin
      next_start = start;
      if (start && !busy) begin
        w = '{kind, address, value};
        machine_step(w);
        words_taken++;
        next_start = 1'b0;
      end
      if (!next_start && pending_words.size() > 0) begin
        if (words_taken < words_total / 3)          gap_pct = 26;
        else if (words_taken < 2 * words_total / 3) gap_pct = 84;
        else                                        gap_pct = 0;
        if ($urandom_range(0, 99) >= gap_pct) begin
          w = pending_words.pop_front();
          kind    <= w.kind;
          address <= w.address;
          value   <= w.value;
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(status), 32'd0);
      end else begin
        e = expected_results.pop_front();
        if (result_kind !== e.result_kind)
          report_mismatch("result_kind", 32'(result_kind), 32'(e.result_kind));
        if (out_char !== e.out_char) report_mismatch("out_char", 32'(out_char), 32'(e.out_char));
        if (status !== e.status) report_mismatch("status", 32'(status), 32'(e.status));
        if (read_data !== e.read_data) report_mismatch("read_data", read_data, e.read_data);
        if (program_counter !== e.program_counter)
          report_mismatch("program_counter", 32'(program_counter), 32'(e.program_counter));
        if (last !== e.last) report_mismatch("last", 32'(last), 32'(e.last));
      end
    end
  end

  initial begin
    for (int i = 0; i <= MEM_CELLS; i++) mem_model[i] = '0;
    for (int i = 0; i < DS_DEPTH; i++) dstack[i] = '0;
    for (int i = 0; i < RS_DEPTH; i++) rstack[i] = '0;
    dptr = 0;
    rptr = 0;
    pc_model = '0;
    wip = '0;

    // Directed part: memory extremes, spare kinds, and the corner cases.
    add_word(KIND_EXEC, '0, '0);                      // return depth zero: finishes
    add_word(KIND_EXEC, '0, '0);                      // execute while finished
    add_word(KIND_LOAD, MEM_CELLS, 32'h8000_0000);
    add_word(KIND_READ, MEM_CELLS, '0);
    add_word(KIND_LOAD, '1, 32'hFFFF_FFFF);          // beyond memory: ignored
    add_word(KIND_READ, '1, '0);
    add_word(KIND_SPARE_LO, '1, 32'h7FFF_FFFF);
    add_word(KIND_SPARE_HI, '0, '0);
    run_one(ADDR_W'(10), pack_ops(OP_DIVMOD, OP_NOP, OP_NOP, OP_NOP), 32'd17, 32'd0);
    run_one(ADDR_W'(11), pack_ops(OP_DIVMOD, OP_IO, OP_IO, OP_NOP),
            32'h8000_0000, 32'hFFFF_FFFF);
    run_one(ADDR_W'(12), pack_ops(OP_SHIFT, OP_DUP, OP_FETCH, OP_HALT),
            32'h8000_0000, 32'd40);
    run_one(ADDR_W'(13), pack_ops(OP_STORE, OP_DEVN, OP_QUERY, OP_IO), 32'd5, 32'hFFFF_FFF0);
    run_one(ADDR_W'(14), pack_ops(8'd30, OP_NOP, OP_NOP, 8'hFF), 32'd0, 32'd0);
    add_word(KIND_LOAD, ADDR_W'(20), pack_ops(OP_DROP, OP_DROP, OP_DROP, OP_DROP));
    add_word(KIND_START, ADDR_W'(20), '0);
    add_word(KIND_EXEC, '0, '0);                      // drop below the bottom
    add_word(KIND_START, MEM_CELLS, '0);
    add_word(KIND_EXEC, '0, '0);

    while (pending_words.size() < WORD_TARGET) begin
      if ($urandom_range(0, 9) < 8) random_program();
      else random_noise();
    end
    words_total = pending_words.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_words.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/psm_pkg.sv
rtl/core/psm_front.sv
rtl/core/psm_div.sv
rtl/core/psm_back.sv
rtl/core/packed_stack_machine_core.sv
rtl/core/psm_chk.sv
bench/tb_packed_stack_machine_core.sv
